/* sv/aes128_block_encrypt_unit_macros.svh */
// assertion macros for the aes-128 block encrypt unit
`ifndef AES128_BLOCK_ENCRYPT_UNIT_MACROS_SVH
`define AES128_BLOCK_ENCRYPT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define AES_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AES_ASSERT_NEXT(lbl, clk, rst_n, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define AES_ASSERT(lbl, clk, rst_n, prop, msg)
`define AES_ASSERT_NEXT(lbl, clk, rst_n, a, b, msg)
`endif
`endif

/* sv/aes_pkg.sv */
// ----------------------------------------------------------------------------
// aes_pkg
// shared types, constants and round functions for the aes-128 encrypt unit
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned NumRkWords = 44;
  localparam int unsigned QueueDepth = 2;

  localparam logic [0:0] CFG_KEY_HIGH = 1'b0;
  localparam logic [0:0] CFG_KEY_LOW = 1'b1;

  typedef logic [127:0] block_t;

  // front to back control bundle
  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] RCON [11] = '{
    8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // byte k of the state sits at bits 127-8k
  function automatic block_t sub_shift(input block_t s);
    block_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(r + 4*c) -: 8] = SBOX[s[127 - 8*(r + 4*((c + r) % 4)) -: 8]];
      end
    end
    sub_shift = t;
  endfunction

  function automatic block_t mix(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32*c -: 8];
      a1 = s[119 - 32*c -: 8];
      a2 = s[111 - 32*c -: 8];
      a3 = s[103 - 32*c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32*c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[119 - 32*c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[111 - 32*c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[103 - 32*c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    mix = t;
  endfunction

endpackage

/* sv/aes_key_sched.sv */
// ----------------------------------------------------------------------------
// aes_key_sched
// holds the key registers and expands them into eleven round keys after
// each key write; round keys 0 and 1 load together, then one per cycle
// ----------------------------------------------------------------------------
module aes_key_sched (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [0:0]           wr_sel,
  input  logic [63:0]          wr_data,
  output logic                 busy,
  output aes_pkg::block_t      rk [aes_pkg::NumRounds + 1]
);

  logic [63:0]     key_high_r, key_low_r;
  aes_pkg::block_t rk_r [aes_pkg::NumRounds + 1];
  logic [3:0]      step_r, step_nxt;
  logic            busy_r, busy_nxt;
  aes_pkg::block_t next_rk;
  logic [31:0]     tw;
  logic [127:0]    prev;

  // round key 1 chains from the key registers, round key 0 loads alongside
  always_comb begin
    prev = (step_r == 4'd1) ? {key_high_r, key_low_r} : rk_r[step_r - 4'd1];
    tw = aes_pkg::sub_word({prev[23:0], prev[31:24]}) ^ {aes_pkg::RCON[step_r], 24'h0};
    next_rk[127:96] = prev[127:96] ^ tw;
    next_rk[95:64]  = prev[95:64] ^ next_rk[127:96];
    next_rk[63:32]  = prev[63:32] ^ next_rk[95:64];
    next_rk[31:0]   = prev[31:0] ^ next_rk[63:32];
  end

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (wr_en) begin
      busy_nxt = 1'b1;
      step_nxt = 4'd1;
    end else if (busy_r) begin
      if (step_r == 4'(aes_pkg::NumRounds)) begin
        busy_nxt = 1'b0;
      end else begin
        step_nxt = step_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 4'd1;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (wr_en) begin
      if (wr_sel == aes_pkg::CFG_KEY_HIGH) begin
        key_high_r <= wr_data;
      end else begin
        key_low_r <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      if (step_r == 4'd1) begin
        rk_r[0] <= {key_high_r, key_low_r};
      end
    end
  end

  // round key 0 loads on the first step; later keys follow the chain
  for (genvar g = 1; g <= aes_pkg::NumRounds; g++) begin : g_rk
    always_ff @(posedge clk) begin
      if (busy_r && step_r == 4'(g)) begin
        rk_r[g] <= next_rk;
      end
    end
  end

  assign busy = busy_r;
  assign rk = rk_r;

endmodule

/* sv/aes_front.sv */
// ----------------------------------------------------------------------------
// aes_front
// input stage and short queue feeding the round pipeline
// ----------------------------------------------------------------------------
module aes_front #(
  parameter int unsigned Depth = aes_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  aes_pkg::block_t  in_data,
  input  logic             hold,
  output aes_pkg::hs_t     q_hs,
  input  logic             q_pop,
  output aes_pkg::block_t  q_data
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  aes_pkg::block_t mem_r [Depth];
  logic [Aw-1:0]   wp_r, rp_r;
  logic [Aw:0]     cnt_r;
  logic            push, pop;

  assign in_ready = (cnt_r != (Aw+1)'(Depth));
  assign push = in_valid && in_ready;
  assign pop = q_pop && (cnt_r != '0) && !hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == Aw'(Depth - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == Aw'(Depth - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_data;
    end
  end

  assign q_data = mem_r[rp_r];
  assign q_hs.valid = (cnt_r != '0) && !hold;
  assign q_hs.ready = pop;

endmodule

/* sv/aes_back.sv */
// ----------------------------------------------------------------------------
// aes_back
// unrolled round pipeline with a stall-able output register
// ----------------------------------------------------------------------------
module aes_back (
  input  logic             clk,
  input  logic             rst_n,
  input  aes_pkg::hs_t     q_hs,
  output logic             q_pop,
  input  aes_pkg::block_t  q_data,
  input  aes_pkg::block_t  rk [aes_pkg::NumRounds + 1],
  output logic             out_valid,
  input  logic             out_ready,
  output aes_pkg::block_t  out_data,
  output logic             empty
);

  localparam int unsigned N = aes_pkg::NumRounds;

  aes_pkg::block_t st_r [N + 1];
  logic            v_r  [N + 1];
  logic            adv  [N + 1];

  // stage 0 is the initial key add, stage N is the output register
  always_comb begin
    adv[N] = !v_r[N] || out_ready;
    for (int i = N - 1; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i + 1];
    end
  end

  assign q_pop = q_hs.valid && adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= N; i++) begin
        v_r[i] <= 1'b0;
      end
    end else begin
      if (adv[0]) begin
        v_r[0] <= q_hs.valid;
      end
      for (int i = 1; i <= N; i++) begin
        if (adv[i]) begin
          v_r[i] <= v_r[i - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      st_r[0] <= q_data ^ rk[0];
    end
  end

  for (genvar g = 1; g <= N; g++) begin : g_round
    always_ff @(posedge clk) begin
      if (adv[g]) begin
        if (g == N) begin
          st_r[g] <= aes_pkg::sub_shift(st_r[g - 1]) ^ rk[g];
        end else begin
          st_r[g] <= aes_pkg::mix(aes_pkg::sub_shift(st_r[g - 1])) ^ rk[g];
        end
      end
    end
  end

  always_comb begin
    empty = 1'b1;
    for (int i = 0; i <= N; i++) begin
      if (v_r[i]) begin
        empty = 1'b0;
      end
    end
  end

  assign out_valid = v_r[N];
  assign out_data = st_r[N];

endmodule

/* sv/aes128_block_encrypt_unit.sv */
// ----------------------------------------------------------------------------
// aes128_block_encrypt_unit
// aes-128 encryption of one 128-bit block per item
// ----------------------------------------------------------------------------
// usage:
//   write key_high (index 0) and key_low (index 1) on the cfg channel while
//   idle; each write starts a key expansion, during which input items wait
//   in the queue
//   in channel carries plaintext halves, out channel ciphertext halves
//   data path: an item sits in the input queue, then passes 11 pipeline
//   stages, the last of which is the output register
//   throughput: one item per cycle without stalls or key expansion, set by
//   the fully unrolled round pipeline (one register stage per round)
//   a stalled receiver holds the output register; the pipeline compresses
//   its bubbles and then stops, and the two-entry queue fills before
//   in_ready drops
//   reset clears the key registers, the queue and all stage valid bits
//   cfg_ready is always high
// ----------------------------------------------------------------------------
`include "aes128_block_encrypt_unit_macros.svh"

module aes128_block_encrypt_unit #(
  parameter int unsigned QueueDepth = aes_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_plain_high,
  input  logic [63:0] in_plain_low,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_cipher_high,
  output logic [63:0] out_cipher_low
);

  aes_pkg::block_t rk [aes_pkg::NumRounds + 1];
  aes_pkg::block_t q_data, out_data;
  aes_pkg::hs_t    q_hs;
  logic            q_pop, ks_busy, empty, cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr = cfg_valid && cfg_ready;

  aes_key_sched u_ks (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_wr),
    .wr_sel  (cfg_index),
    .wr_data (cfg_data),
    .busy    (ks_busy),
    .rk      (rk)
  );

  aes_front #(.Depth(QueueDepth)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  ({in_plain_high, in_plain_low}),
    .hold     (ks_busy || cfg_wr),
    .q_hs     (q_hs),
    .q_pop    (q_pop),
    .q_data   (q_data)
  );

  aes_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_hs      (q_hs),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .rk        (rk),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .empty     (empty)
  );

  assign out_cipher_high = out_data[127:64];
  assign out_cipher_low  = out_data[63:0];

  `AES_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "output changed under stall")
  `AES_ASSERT(a_no_pop_busy, clk, rst_n, ks_busy |-> !q_pop, "block entered during key expansion")
  `AES_ASSERT_NEXT(a_empty_nout, clk, rst_n, empty, !out_valid, "result from empty pipeline")

endmodule
